[src/alsid_pkg.sv]
// Package: shared types and codes for the array list search/insert/delete block.
`default_nettype none

package alsid_pkg;

  // Command codes
  localparam logic [1:0] CMD_DUMP       = 2'd0;
  localparam logic [1:0] CMD_INS_BEFORE = 2'd1;
  localparam logic [1:0] CMD_INS_AFTER  = 2'd2;
  localparam logic [1:0] CMD_DELETE     = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] key;
    logic [15:0] new_value;
  } alsid_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  position;
    logic [15:0] entry_value;
    logic        last;
  } alsid_out_t;

  // Decoded command class
  typedef struct packed {
    logic dump;
    logic ins;
    logic after;
    logic del;
  } alsid_op_t;

  // Job handed from front to back
  typedef struct packed {
    alsid_op_t   op;
    logic [15:0] key;
    logic [15:0] new_value;
  } alsid_job_t;

endpackage

`default_nettype wire

[src/alsid_front.sv]
// Front end: accept input beats, decode the command, queue jobs for the back end.
`default_nettype none

module alsid_front import alsid_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire alsid_in_t  in_item,
  output logic            job_valid,
  input  wire logic       job_pop,
  output alsid_job_t      job
);

  alsid_job_t  q_r [2];
  logic        wp_r, wp_nxt;
  logic        rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        wr_en, rd_en;
  alsid_job_t  dec;

  // Classify the command
  always_comb begin
    dec           = '0;
    dec.key       = in_item.key;
    dec.new_value = in_item.new_value;
    case (in_item.cmd)
      CMD_DUMP:       dec.op.dump  = 1'b1;
      CMD_INS_BEFORE: dec.op.ins   = 1'b1;
      CMD_INS_AFTER: begin
        dec.op.ins   = 1'b1;
        dec.op.after = 1'b1;
      end
      CMD_DELETE:     dec.op.del   = 1'b1;
      default:        dec.op.dump  = 1'b1;
    endcase
  end

  assign in_full   = (cnt_r == 2'd2);
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rp_r];
  assign wr_en     = in_push && !in_full;
  assign rd_en     = job_pop && job_valid;

  always_comb begin
    wp_nxt  = wr_en ? ~wp_r : wp_r;
    rp_nxt  = rd_en ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wp_r] <= dec;
    end
  end

endmodule

`default_nettype wire

[src/alsid_back.sv]
// Back end: list storage, parallel key search, shift insert/delete and dump sequencing.
`default_nettype none

module alsid_back import alsid_pkg::*; #(
  parameter int CAPACITY = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        job_valid,
  output logic             job_pop,
  input  wire alsid_job_t  job,
  output logic             res_push,
  input  wire logic        res_full,
  output alsid_out_t       res
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SRCH = 4'b0010,
    S_EXEC = 4'b0100,
    S_DUMP = 4'b1000
  } alsid_state_t;

  alsid_state_t      state_r, state_nxt;
  alsid_job_t        job_r, job_nxt;
  logic [15:0]       ent_r [CAPACITY];
  logic [15:0]       ent_nxt [CAPACITY];
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              hit_r, hit_nxt;
  logic [IW-1:0]     pos_r, pos_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [CAPACITY-1:0] match;
  logic [IW-1:0]     first;
  logic [IW-1:0]     ins_pos;
  logic [IW-1:0]     res_idx;
  logic [IW+2:0]     pos_ext;
  logic              dump_last;

  // Compare all live entries at once, take the lowest match
  always_comb begin
    first = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (CW'(i) < cnt_r) && (ent_r[i] == job_r.key);
    end
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        first = IW'(i);
      end
    end
  end

  assign ins_pos   = (cnt_r == '0) ? '0 : pos_r + IW'(job_r.op.after);
  assign dump_last = ((CW'(idx_r) + CW'(1)) == cnt_r);
  assign pos_ext   = {3'b000, res_idx};

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    cnt_nxt   = cnt_r;
    hit_nxt   = hit_r;
    pos_nxt   = pos_r;
    idx_nxt   = idx_r;
    ent_nxt   = ent_r;
    job_pop   = 1'b0;
    res_push  = 1'b0;
    res_idx   = '0;
    res       = '0;
    case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          job_nxt   = job;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        hit_nxt   = |match;
        pos_nxt   = first;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!res_full) begin
          res_push  = 1'b1;
          res.last  = 1'b1;
          state_nxt = S_IDLE;
          if (job_r.op.dump) begin
            if (cnt_r == '0) begin
              res.status = ST_EMPTY;
            end else begin
              res_push  = 1'b0;
              idx_nxt   = '0;
              state_nxt = S_DUMP;
            end
          end else if (job_r.op.del) begin
            if (cnt_r == '0) begin
              res.status = ST_EMPTY;
            end else if (!hit_r) begin
              res.status = ST_NOT_FOUND;
            end else begin
              for (int i = 0; i < CAPACITY - 1; i++) begin
                if (IW'(i) >= pos_r) begin
                  ent_nxt[i] = ent_r[i + 1];
                end
              end
              cnt_nxt    = cnt_r - CW'(1);
              res.status = ST_OK;
              res_idx    = pos_r;
            end
          end else begin
            if (cnt_r != '0 && !hit_r) begin
              res.status = ST_NOT_FOUND;
            end else if (cnt_r == CW'(CAPACITY)) begin
              res.status = ST_FULL;
            end else begin
              for (int i = 1; i < CAPACITY; i++) begin
                if (IW'(i) > ins_pos) begin
                  ent_nxt[i] = ent_r[i - 1];
                end
              end
              ent_nxt[ins_pos] = job_r.new_value;
              cnt_nxt          = cnt_r + CW'(1);
              res.status       = ST_OK;
              res_idx          = ins_pos;
            end
          end
          res.position = pos_ext[2:0];
        end
      end
      S_DUMP: begin
        if (!res_full) begin
          res_push        = 1'b1;
          res_idx         = idx_r;
          res.status      = ST_OK;
          res.position    = pos_ext[2:0];
          res.entry_value = ent_r[idx_r];
          res.last        = dump_last;
          idx_nxt         = idx_r + IW'(1);
          if (dump_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    hit_r <= hit_nxt;
    pos_r <= pos_nxt;
    idx_r <= idx_nxt;
    ent_r <= ent_nxt;
  end

endmodule

`default_nettype wire

[src/alsid_rq.sv]
// Result queue: two-entry buffer between the back end and the output port.
`default_nettype none

module alsid_rq import alsid_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        res_push,
  output logic             res_full,
  input  wire alsid_out_t  res,
  output logic             out_empty,
  input  wire logic        out_pop,
  output alsid_out_t       out_item
);

  alsid_out_t  q_r [2];
  logic        wp_r, wp_nxt;
  logic        rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        wr_en, rd_en;

  assign res_full  = (cnt_r == 2'd2);
  assign out_empty = (cnt_r == 2'd0);
  assign out_item  = q_r[rp_r];
  assign wr_en     = res_push && !res_full;
  assign rd_en     = out_pop && !out_empty;

  always_comb begin
    wp_nxt  = wr_en ? ~wp_r : wp_r;
    rp_nxt  = rd_en ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wp_r] <= res;
    end
  end

endmodule

`default_nettype wire

[src/array_list_search_insert_delete.sv]
// Top level: ordered list with search, insert-before/after, delete and dump.
// Path: a command beat is written into the input queue, popped by the back end,
//   searched, executed once the result queue has room, then queued there.
// Sequence: insert and delete pass the pop, search and execute states; a dump
//   then sends one result beat per cycle while the result queue has room.
// The back end's search/execute sequence sets the rate; the input queue keeps
//   taking command beats, up to two, while it works.
// Reset (rst_n low, synchronous): queues drain to empty, fill count clears to zero.
`default_nettype none

module array_list_search_insert_delete import alsid_pkg::*; #(
  parameter int CAPACITY = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // command channel
  input  wire logic       in_push,
  output logic            in_full,
  input  wire alsid_in_t  in_item,
  // result channel
  output logic            out_empty,
  input  wire logic       out_pop,
  output alsid_out_t      out_item
);

  // Front to back job handoff
  logic        job_valid;
  logic        job_pop;
  alsid_job_t  job;

  // Back to result queue
  logic        res_push;
  logic        res_full;
  alsid_out_t  res;

  // Decode commands and hold up to two jobs ahead of the back end
  alsid_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job       (job)
  );

  // Search the list, shift entries, produce result beats
  alsid_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .job       (job),
    .res_push  (res_push),
    .res_full  (res_full),
    .res       (res)
  );

  // Hold result beats until the consumer pops them; stall the back end when full
  alsid_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res_full  (res_full),
    .res       (res),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

[src/alsid_chk.sv]
// Checker: port-level properties of the list block, bound to the top level.
`default_nettype none

module alsid_chk import alsid_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_push,
  input wire logic       in_full,
  input wire alsid_in_t  in_item,
  input wire logic       out_empty,
  input wire logic       out_pop,
  input wire alsid_out_t out_item
);

  // Reset drains the result side
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // Reset leaves room for a command beat
  a_rst_room: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("command queue full after reset");

  // Any failing status is a single final beat with zero position and value
  a_fail_beat: assert property (@(posedge clk) disable iff (!rst_n)
      (!out_empty && out_item.status != ST_OK) |->
      (out_item.last && out_item.position == 3'd0 && out_item.entry_value == 16'd0))
    else $error("non-ok result beat carries data or lacks last");

  // A waiting result beat holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("waiting result beat changed before pop");

endmodule

bind array_list_search_insert_delete alsid_chk u_alsid_chk (.*);

`default_nettype wire
